FILE: hdl/irpdt_pkg.sv
// Shared constants and register indexes for the pulse-distance IR transmitter.
package irpdt_pkg;

  localparam int FRAME_BITS = 32;
  localparam int WORD_W     = 32;
  localparam int TICK_W     = 16;
  localparam int BITS_W     = 6;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_DUTY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE_TICKS = 3'd5;

  // Register reset values
  localparam logic [TICK_W-1:0] RST_CARRIER_DUTY     = 16'd0;
  localparam logic [TICK_W-1:0] RST_MARK_TICKS       = 16'd560;
  localparam logic [TICK_W-1:0] RST_ONE_SPACE_TICKS  = 16'd1690;
  localparam logic [TICK_W-1:0] RST_ZERO_SPACE_TICKS = 16'd560;
  localparam logic [TICK_W-1:0] RST_LEAD_MARK_TICKS  = 16'd9000;
  localparam logic [TICK_W-1:0] RST_LEAD_SPACE_TICKS = 16'd4500;

  // Data bits still to follow the first one
  localparam logic [BITS_W-1:0] BITS_AFTER_FIRST = BITS_W'((FRAME_BITS - 1) & 63);

  // Item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

endpackage

FILE: hdl/ir_pulse_distance_transmitter_core.sv
// Pulse-distance IR frame transmitter: frame sequencer with registered result beat.
// Latency: the result beat is registered, valid the cycle after its input beat is accepted.
// Throughput: one item per cycle; a new item is taken while the last result is
//   being taken, and only a stalled result register holds the input back.
// The whole tick step (phase length select, counter compare, phase advance) is
//   one pass of logic between the state registers.
// Reset (synchronous, rst high): idle, counters cleared, registers at defaults.
module ir_pulse_distance_transmitter_core
  import irpdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [WORD_W-1:0]    frame_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TICK_W-1:0]    carrier_compare,
  output logic                 busy_res,
  output logic                 frame_done,
  output logic                 send_rejected
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_END_MARK   = 3'd5
  } phase_t;

  logic [TICK_W-1:0] carrier_duty, mark_ticks, one_space_ticks;
  logic [TICK_W-1:0] zero_space_ticks, lead_mark_ticks, lead_space_ticks;

  phase_t            phase, phase_next, phase_w;
  logic [TICK_W-1:0] tick_count, tick_count_next, tick_w;
  logic [WORD_W-1:0] shift_word, shift_word_next, shift_w;
  logic [BITS_W-1:0] bits_left, bits_left_next, bits_w;

  logic              accept;
  logic              running;
  logic              run_w;
  logic [TICK_W-1:0] len_raw;
  logic [TICK_W:0]   len;
  logic [TICK_W:0]   spent;
  logic [TICK_W-1:0] compare_next;
  logic              done_next;
  logic              rejected_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_duty     <= RST_CARRIER_DUTY;
      mark_ticks       <= RST_MARK_TICKS;
      one_space_ticks  <= RST_ONE_SPACE_TICKS;
      zero_space_ticks <= RST_ZERO_SPACE_TICKS;
      lead_mark_ticks  <= RST_LEAD_MARK_TICKS;
      lead_space_ticks <= RST_LEAD_SPACE_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CARRIER_DUTY:     carrier_duty     <= cfg_data;
        REG_MARK_TICKS:       mark_ticks       <= cfg_data;
        REG_ONE_SPACE_TICKS:  one_space_ticks  <= cfg_data;
        REG_ZERO_SPACE_TICKS: zero_space_ticks <= cfg_data;
        REG_LEAD_MARK_TICKS:  lead_mark_ticks  <= cfg_data;
        REG_LEAD_SPACE_TICKS: lead_space_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame step: load on a send while idle (a send while running is rejected), then advance one tick
  always_comb begin
    running = (phase == PH_LEAD_MARK) || (phase == PH_LEAD_SPACE) ||
              (phase == PH_BIT_MARK)  || (phase == PH_BIT_SPACE)  ||
              (phase == PH_END_MARK);
    phase_w       = phase;
    tick_w        = tick_count;
    shift_w       = shift_word;
    bits_w        = bits_left;
    run_w         = running;
    rejected_next = 1'b0;

    if (!running) begin
      phase_w = PH_IDLE;
      if (op == OP_SEND) begin
        shift_w = frame_data;
        phase_w = PH_LEAD_MARK;
        tick_w  = '0;
        bits_w  = '0;
        run_w   = 1'b1;
      end
    end else if (op == OP_SEND) begin
      rejected_next = 1'b1;
    end

    // Length of the phase in hand; zero acts as one tick
    case (phase_w)
      PH_LEAD_MARK:  len_raw = lead_mark_ticks;
      PH_LEAD_SPACE: len_raw = lead_space_ticks;
      PH_BIT_MARK:   len_raw = mark_ticks;
      PH_BIT_SPACE:  len_raw = shift_w[WORD_W-1] ? one_space_ticks : zero_space_ticks;
      default:       len_raw = mark_ticks;
    endcase
    len   = (len_raw == '0) ? (TICK_W+1)'(1) : {1'b0, len_raw};
    spent = {1'b0, tick_w} + (TICK_W+1)'(1);

    phase_next      = phase_w;
    tick_count_next = tick_w;
    shift_word_next = shift_w;
    bits_left_next  = bits_w;
    compare_next    = '0;
    done_next       = 1'b0;

    if (run_w) begin
      if ((phase_w == PH_LEAD_MARK) || (phase_w == PH_BIT_MARK) ||
          (phase_w == PH_END_MARK)) begin
        compare_next = carrier_duty;
      end
      if (spent < len) begin
        tick_count_next = spent[TICK_W-1:0];
      end else begin
        tick_count_next = '0;
        case (phase_w)
          PH_LEAD_MARK:  phase_next = PH_LEAD_SPACE;
          PH_LEAD_SPACE: begin
            phase_next     = PH_BIT_MARK;
            bits_left_next = BITS_AFTER_FIRST;
          end
          PH_BIT_MARK:   phase_next = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            shift_word_next = {shift_w[WORD_W-2:0], 1'b0};
            if (bits_w == '0) begin
              phase_next = PH_END_MARK;
            end else begin
              bits_left_next = bits_w - BITS_W'(1);
              phase_next     = PH_BIT_MARK;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end
    end
  end

  // Hold state and the result register; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      shift_word <= '0;
      bits_left  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        shift_word <= shift_word_next;
        bits_left  <= bits_left_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      carrier_compare <= compare_next;
      busy_res        <= (phase_next != PH_IDLE);
      frame_done      <= done_next;
      send_rejected   <= rejected_next;
    end
  end

  // A finished frame leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (!busy_res && phase == PH_IDLE))
    else $error("frame_done without return to idle");

  // Carrier only while a frame runs or on its final tick
  a_carrier_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && carrier_compare != '0) |-> (busy_res || frame_done))
    else $error("carrier driven outside a frame");

  // Bit counter is only loaded once the lead space ends
  a_lead_bits_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEAD_MARK || phase == PH_LEAD_SPACE) |-> (bits_left == '0))
    else $error("bit counter set during lead");

  // Busy result tracks the sequencer state after the beat
  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy_res == (phase != PH_IDLE)))
    else $error("busy_res out of step with phase");

endmodule
